### rtl/opfb_pkg.sv
// opfb_pkg: payload types, input kind codes and display command constants
// for the page-mode frame buffer. No dependencies; used by the core and the testbench.
package opfb_pkg;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic       pixel_on;
	} item_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       is_command;
		logic       frame_end;
	} result_t;

	localparam logic [1:0] KIND_DRAW    = 2'd0;
	localparam logic [1:0] KIND_CLEAR   = 2'd1;
	localparam logic [1:0] KIND_REFRESH = 2'd2;

	localparam logic [7:0] PAGE_CMD         = 8'hB0;
	localparam logic [7:0] COL_LO_CMD       = 8'h00;
	localparam logic [7:0] COL_HI_CMD       = 8'h10;
	localparam logic [7:0] COLUMN_START_RST = 8'h02;

endpackage

### rtl/opfb_stream_if.sv
// opfb_stream_if: valid/ready channel carrying one payload word.
// Payload type comes from opfb_pkg at the instantiation site.
interface opfb_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/oled_page_frame_buffer_core.sv
// oled_page_frame_buffer_core: frame store with pixel draw, clear and refresh stream.
// Depends on opfb_pkg and opfb_stream_if.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------
//   item     | in  | kind, x_pos, y_pos, pixel_on
//   result   | out | stream_byte, is_command, frame_end
//   cfg      | in  | cfg_we / cfg_data -> column_start
//
// One word is accepted every cycle unless clear is busy or refresh output stalls.
// Each word does one read of the store (one read port, one write port); draws write
// back in the following cycle, with a bypass when the next word hits the same byte.
// Clear (and reset) sweeps the store, one byte a cycle, with item.ready low
// throughout. A refresh result waiting in the output register stalls the input
// only when a second refresh result is ready behind it.
module oled_page_frame_buffer_core #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	opfb_stream_if.sink         item,
	opfb_stream_if.source       result,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data
);

	localparam int DEPTH    = PAGES * COLUMNS;
	localparam int AW       = $clog2(DEPTH);
	localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int OW       = $clog2(COLUMNS + 3);
	localparam int OFF_LAST = COLUMNS + 2;

	logic [7:0] mem [DEPTH];

	logic [7:0]    column_start_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;
	logic [PW-1:0] page_q;
	logic [OW-1:0] off_q;

	// stage 1: memory read in flight
	logic          wr_s1, res_s1, byp_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1, byp_data_s1, rd_data_s1, byte_s1;
	logic          on_s1, cmd_s1, end_s1;

	logic          out_valid_q;
	opfb_pkg::result_t out_data_q;

	logic          out_free, adv, accept;
	logic          draw_ok;
	logic [AW-1:0] draw_addr, data_addr, rd_addr;
	logic [OW-1:0] col;
	logic [7:0]    cur_data, wdata, ref_byte;
	logic          ref_cmd, ref_end;

	assign out_free     = !out_valid_q || result.ready;
	assign adv          = !res_s1 || out_free;
	assign item.ready   = adv && !clr_busy_q;
	assign accept       = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	assign draw_ok   = ({1'b0, item.data.x_pos} < 9'(COLUMNS))
		&& ({1'b0, item.data.y_pos} < 9'(8 * PAGES));
	assign draw_addr = AW'(AW'(item.data.y_pos[7:3]) * COLUMNS) + AW'(item.data.x_pos);
	assign col       = off_q - OW'(3);
	assign data_addr = AW'(AW'(page_q) * COLUMNS) + AW'(col);
	assign rd_addr   = (item.data.kind == opfb_pkg::KIND_DRAW) ? draw_addr : data_addr;

	assign cur_data = byp_s1 ? byp_data_s1 : rd_data_s1;
	assign wdata    = on_s1 ? (cur_data | mask_s1) : (cur_data & ~mask_s1);

	always_comb begin
		ref_cmd = 1'b1;
		ref_end = 1'b0;
		if (off_q == OW'(0)) begin
			ref_byte = 8'(opfb_pkg::PAGE_CMD + 8'(page_q));
		end else if (off_q == OW'(1)) begin
			ref_byte = opfb_pkg::COL_LO_CMD | {4'h0, column_start_q[3:0]};
		end else if (off_q == OW'(2)) begin
			ref_byte = opfb_pkg::COL_HI_CMD | {4'h0, column_start_q[7:4]};
		end else begin
			ref_byte = '0;
			ref_cmd  = 1'b0;
			ref_end  = (page_q == PW'(PAGES - 1)) && (off_q == OW'(OFF_LAST));
		end
	end

	// store: clear sweep owns the write port; reads happen on accept only
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_s1) begin
			mem[addr_s1] <= wdata;
		end
		if (accept) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_start_q <= opfb_pkg::COLUMN_START_RST;
		end else if (cfg_we) begin
			column_start_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end else if (accept && item.data.kind == opfb_pkg::KIND_CLEAR) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			off_q  <= '0;
		end else if (accept && item.data.kind == opfb_pkg::KIND_REFRESH) begin
			if (off_q == OW'(OFF_LAST)) begin
				off_q  <= '0;
				page_q <= (page_q == PW'(PAGES - 1)) ? '0 : page_q + PW'(1);
			end else begin
				off_q <= off_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1  <= 1'b0;
			res_s1 <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (adv) begin
			wr_s1  <= accept && item.data.kind == opfb_pkg::KIND_DRAW && draw_ok;
			res_s1 <= accept && item.data.kind == opfb_pkg::KIND_REFRESH;
			if (accept) begin
				byp_s1 <= wr_s1 && (rd_addr == addr_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= rd_addr;
			mask_s1     <= 8'(8'd1 << item.data.y_pos[2:0]);
			on_s1       <= item.data.pixel_on;
			byp_data_s1 <= wdata;
			byte_s1     <= ref_byte;
			cmd_s1      <= ref_cmd;
			end_s1      <= ref_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_s1 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1 && out_free) begin
			out_data_q.stream_byte <= cmd_s1 ? byte_s1 : cur_data;
			out_data_q.is_command  <= cmd_s1;
			out_data_q.frame_end   <= end_s1;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !item.ready)
		else $error("item accepted during clear sweep");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_busy_q && clr_cnt_q == AW'(DEPTH - 1)) |=> !clr_busy_q)
		else $error("clear sweep overran the store");

	a_write_port: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !wr_s1)
		else $error("draw write collides with clear sweep");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1 && out_valid_q && !result.ready) |=> res_s1)
		else $error("stalled refresh result dropped");

	a_stream_range: assert property (@(posedge clk) disable iff (!arst_n)
		(off_q <= OW'(OFF_LAST)) && (page_q <= PW'(PAGES - 1)))
		else $error("stream position out of range");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for oled_page_frame_buffer_core. It keeps its own frame store
// and stream position and checks every refresh word the core returns.
// Depends on opfb_pkg, opfb_stream_if and the core itself.
module tb;

	localparam int COLUMNS      = 128;
	localparam int PAGES        = 8;
	localparam int PAGE_LEN     = COLUMNS + 3;
	localparam int FRAME_LEN    = PAGES * PAGE_LEN;
	localparam int SWEEP_CYCLES = PAGES * COLUMNS + 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 200;
	localparam int BURST_ITEMS  = 150;
	localparam int MAX_REPORTS  = 10;
	localparam int TIMEOUT_NS   = 400_000 * 12;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class frame_scoreboard;
		logic [7:0]  pixels [PAGES*COLUMNS];
		int unsigned stream_pos;
		logic [7:0]  col_start;
		opfb_pkg::result_t words_due [$];
		int unsigned n_fail, n_checked, n_frames, n_cfg;
		int unsigned n_draw, n_skipped, n_clear, n_refresh, n_unused;

		function new();
			foreach (pixels[i]) pixels[i] = 8'h00;
			stream_pos = 0;
			col_start  = opfb_pkg::COLUMN_START_RST;
		endfunction

		function void set_column_start(logic [7:0] v);
			col_start = v;
			n_cfg++;
		endfunction

		function int unsigned pending();
			return words_due.size();
		endfunction

		// column and page of the next refresh word, if it is a data byte
		function bit next_data_byte(output int unsigned col, output int unsigned page);
			int unsigned off;
			off  = stream_pos % PAGE_LEN;
			page = stream_pos / PAGE_LEN;
			col  = (off >= 3) ? off - 3 : 0;
			return off >= 3;
		endfunction

		function void note_failure(string msg);
			n_fail++;
			if (n_fail <= MAX_REPORTS)
				$display("%0t ERROR: %s", $time, msg);
		endfunction

		function void note_item(opfb_pkg::item_t it);
			int unsigned page, off, idx;
			opfb_pkg::result_t w;
			case (it.kind)
				opfb_pkg::KIND_DRAW: begin
					n_draw++;
					if (it.x_pos < COLUMNS && it.y_pos < 8 * PAGES) begin
						idx = (it.y_pos >> 3) * COLUMNS + it.x_pos;
						pixels[idx][it.y_pos[2:0]] = it.pixel_on;
					end else begin
						n_skipped++;
					end
				end
				opfb_pkg::KIND_CLEAR: begin
					n_clear++;
					foreach (pixels[i]) pixels[i] = 8'h00;
				end
				opfb_pkg::KIND_REFRESH: begin
					n_refresh++;
					page = stream_pos / PAGE_LEN;
					off  = stream_pos % PAGE_LEN;
					w.is_command = 1'b1;
					w.frame_end  = 1'b0;
					if (off == 0) begin
						w.stream_byte = opfb_pkg::PAGE_CMD + 8'(page);
					end else if (off == 1) begin
						w.stream_byte = opfb_pkg::COL_LO_CMD | {4'h0, col_start[3:0]};
					end else if (off == 2) begin
						w.stream_byte = opfb_pkg::COL_HI_CMD | {4'h0, col_start[7:4]};
					end else begin
						w.stream_byte = pixels[page * COLUMNS + off - 3];
						w.is_command  = 1'b0;
						w.frame_end   = (stream_pos == FRAME_LEN - 1);
					end
					words_due.push_back(w);
					stream_pos = (stream_pos + 1 >= FRAME_LEN) ? 0 : stream_pos + 1;
				end
				default: begin
					n_unused++;
				end
			endcase
		endfunction

		function void check_result(opfb_pkg::result_t got);
			opfb_pkg::result_t want;
			if (words_due.size() == 0) begin
				note_failure($sformatf("unexpected word: byte %02h cmd %0b end %0b",
					got.stream_byte, got.is_command, got.frame_end));
				return;
			end
			want = words_due.pop_front();
			n_checked++;
			if (want.frame_end)
				n_frames++;
			if (got.stream_byte !== want.stream_byte || got.is_command !== want.is_command ||
					got.frame_end !== want.frame_end)
				note_failure($sformatf(
					"word %0d: expected byte %02h cmd %0b end %0b, got byte %02h cmd %0b end %0b",
					n_checked, want.stream_byte, want.is_command, want.frame_end,
					got.stream_byte, got.is_command, got.frame_end));
		endfunction

		function void final_check();
			if (words_due.size() != 0)
				note_failure($sformatf("%0d refresh words never came out", words_due.size()));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_data;

	opfb_stream_if #(.payload_t(opfb_pkg::item_t))   item_ch ();
	opfb_stream_if #(.payload_t(opfb_pkg::result_t)) result_ch ();

	frame_scoreboard sb;
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	bit          hold_req;
	int unsigned hold_left;
	opfb_pkg::item_t last_draw;

	oled_page_frame_buffer_core #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout: run did not drain");
		$display("Test completed with failures");
		$finish;
	end

	// receiver: random stalls plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.data);
			if (item_ch.valid && item_ch.ready)
				sb.note_item(item_ch.data);
		end
	end

	function automatic opfb_pkg::item_t make_word(logic [1:0] k, logic [7:0] x,
			logic [7:0] y, logic on);
		opfb_pkg::item_t it;
		it.kind     = k;
		it.x_pos    = x;
		it.y_pos    = y;
		it.pixel_on = on;
		return it;
	endfunction

	function automatic opfb_pkg::item_t random_item();
		opfb_pkg::item_t it;
		int unsigned r, col, page;
		it = make_word(opfb_pkg::KIND_DRAW, 8'($urandom), 8'($urandom), 1'($urandom));
		r = $urandom_range(999);
		if (r < 15) begin
			it.kind = opfb_pkg::KIND_CLEAR;
		end else if (r < 40) begin
			it.kind = KIND_UNUSED;
		end else if (r < 740) begin
			it.kind = opfb_pkg::KIND_REFRESH;
		end else begin
			r = $urandom_range(99);
			if (r < 15 && sb.next_data_byte(col, page)) begin
				// lands on the byte the next refresh reads
				it.x_pos = 8'(col);
				it.y_pos = 8'(page * 8 + $urandom_range(7));
			end else if (r < 30) begin
				// same byte as the previous draw, to hit the write-back bypass
				it.x_pos = last_draw.x_pos;
				it.y_pos = {last_draw.y_pos[7:3], 3'($urandom)};
			end else if (r < 90) begin
				it.x_pos = 8'($urandom_range(COLUMNS - 1));
				it.y_pos = 8'($urandom_range(8 * PAGES - 1));
			end
			last_draw = it;
		end
		return it;
	endfunction

	// valid stays high between back-to-back words; accepted at the edge with ready high
	task automatic send_item(input opfb_pkg::item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_column_start(input logic [7:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_column_start(v);
	endtask

	// let results drain, then allow a full clear sweep to finish
	task automatic finish_phase();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SWEEP_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0] cfg_val;
		sb = new();
		last_draw      = '0;
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		hold_left      = 0;
		arst_n         = 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		cfg_we        <= 1'b0;
		cfg_data      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset column start, corners, off-screen draws, bypass, clear mid-refresh
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'hFF, 8'hFF, 1'b1));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd0, 8'd0, 1'b1));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd1, 8'd7, 1'b1));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd2, 8'd5, 1'b1));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd2, 8'd5, 1'b0));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd127, 8'd63, 1'b1));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd128, 8'd0, 1'b1));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd0, 8'd64, 1'b1));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd255, 8'd255, 1'b1));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd3, 8'd1, 1'b1));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd3, 8'd2, 1'b1));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(KIND_UNUSED, 8'hFF, 8'hFF, 1'b1));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_CLEAR, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));
		send_item(make_word(opfb_pkg::KIND_DRAW, 8'd6, 8'd0, 1'b1));
		send_item(make_word(opfb_pkg::KIND_REFRESH, 8'h00, 8'h00, 1'b0));

		for (int ph = 0; ph < 4; ph++) begin
			finish_phase();
			case (ph)
				0: begin
					cfg_val = 8'd0;
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					cfg_val = 8'd131;
					send_gap_pct = 81;
					recv_stall_pct = 0;
				end
				2: begin
					cfg_val = 8'd124;
					send_gap_pct = 0;
					recv_stall_pct = 81;
				end
				default: begin
					cfg_val = 8'($urandom_range(131));
					send_gap_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			write_column_start(cfg_val);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == PHASE_ITEMS / 2) begin
					// output held off while refresh words keep coming: core must back up
					hold_req = 1'b1;
					repeat (BURST_ITEMS)
						send_item(make_word(opfb_pkg::KIND_REFRESH, 8'($urandom),
							8'($urandom), 1'($urandom)));
				end
				send_item(random_item());
			end
		end
		finish_phase();
		sb.final_check();

		$display("Covered %0d draws (%0d off screen), %0d clears, %0d unused-kind words.",
			sb.n_draw, sb.n_skipped, sb.n_clear, sb.n_unused);
		$display("Checked %0d refresh words over %0d full frames, %0d column start settings.",
			sb.n_checked, sb.n_frames, sb.n_cfg);
		if (sb.n_fail == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d failures", sb.n_fail);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
